// ----- src/deauth_flood_monitor_core_assert.svh -----
// ----------------------------------------------------------------------------
// Deauth flood monitor assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DEAUTH_FLOOD_MONITOR_CORE_ASSERT_SVH
`define DEAUTH_FLOOD_MONITOR_CORE_ASSERT_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define DFM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("deauth_flood_monitor_core: assertion failed");
// Expression must never be true outside reset.
`define DFM_ASSERT_NEVER(lbl, clk, rstn, expr) \
  `DFM_ASSERT(lbl, clk, rstn, !(expr))
`else
`define DFM_ASSERT(lbl, clk, rstn, prop)
`define DFM_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ----- src/dfm_pkg.sv -----
// ----------------------------------------------------------------------------
// Deauth flood monitor package
// Field widths, codes and the command and status types shared by the modules.
// ----------------------------------------------------------------------------
package dfm_pkg;

  // Field widths.
  localparam int KIND_W     = 2;
  localparam int FC_W       = 8;
  localparam int LEN_W      = 12;
  localparam int BSSID_W    = 48;
  localparam int RSSI_W     = 8;
  localparam int CNT_W      = 16;
  localparam int BKT_W      = 16;
  localparam int RATE_W     = 19;
  localparam int TOT_W      = 32;
  localparam int CLASS_W    = 2;
  localparam int RPT_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 19;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_THR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_CNT = 1'd1;
  localparam logic [RATE_W-1:0]    THR_RESET      = 19'd12;
  localparam logic [RPT_W-1:0]     RPT_RESET      = 3'd6;

  // Frame qualification constants.
  localparam logic [LEN_W-1:0] MIN_FRAME_LEN    = 12'd24;
  localparam logic [1:0]       TYPE_MGMT        = 2'h0;
  localparam logic [3:0]       SUBTYPE_DEAUTH   = 4'd12;
  localparam logic [3:0]       SUBTYPE_DISASSOC = 4'd10;

  // Saturation limits.
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_FRAME  = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_REPORT = 2'd3
  } dfm_kind_e;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_NONE     = 2'd0,
    CLASS_DEAUTH   = 2'd1,
    CLASS_DISASSOC = 2'd2
  } dfm_class_e;

  // One offender table entry.
  typedef struct packed {
    logic [BSSID_W-1:0]        bssid;
    logic [CNT_W-1:0]          count;
    logic signed [RSSI_W-1:0]  rssi;
  } dfm_entry_t;

  // One result transaction.
  typedef struct packed {
    logic [CLASS_W-1:0]        frame_class;
    logic                      table_drop;
    logic [RATE_W-1:0]         window_rate;
    logic                      alert;
    logic [TOT_W-1:0]          deauth_total;
    logic [TOT_W-1:0]          disassoc_total;
    logic                      entry_valid;
    logic [BSSID_W-1:0]        entry_bssid;
    logic [CNT_W-1:0]          entry_count;
    logic signed [RSSI_W-1:0]  entry_rssi;
    logic                      last;
  } dfm_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic in_ready;
    logic scan_start;
    logic tbl_upd;
    logic best_upd;
    logic next_pass;
    logic out_load;
    logic out_entry;
  } dfm_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic      in_valid;
    dfm_kind_e kind;
    logic      qualify;
    logic      limit_zero;
    logic      hit;
    logic      done;
    logic      last_entry;
    logic      out_free;
  } dfm_sts_t;

endpackage

// ----- src/dfm_if.sv -----
// ----------------------------------------------------------------------------
// Deauth flood monitor channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface dfm_in_if import dfm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic                     mgmt_frame;
  logic [FC_W-1:0]          frame_ctrl;
  logic [LEN_W-1:0]         frame_len;
  logic [BSSID_W-1:0]       bssid;
  logic signed [RSSI_W-1:0] rssi;

  modport source (output valid, kind, mgmt_frame, frame_ctrl, frame_len, bssid, rssi,
                  input ready);
  modport sink (input valid, kind, mgmt_frame, frame_ctrl, frame_len, bssid, rssi,
                output ready);
endinterface

interface dfm_out_if import dfm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CLASS_W-1:0]       frame_class;
  logic                     table_drop;
  logic [RATE_W-1:0]        window_rate;
  logic                     alert;
  logic [TOT_W-1:0]         deauth_total;
  logic [TOT_W-1:0]         disassoc_total;
  logic                     entry_valid;
  logic [BSSID_W-1:0]       entry_bssid;
  logic [CNT_W-1:0]         entry_count;
  logic signed [RSSI_W-1:0] entry_rssi;
  logic                     last;

  modport source (output valid, frame_class, table_drop, window_rate, alert, deauth_total,
                  disassoc_total, entry_valid, entry_bssid, entry_count, entry_rssi, last,
                  input ready);
  modport sink (input valid, frame_class, table_drop, window_rate, alert, deauth_total,
                disassoc_total, entry_valid, entry_bssid, entry_count, entry_rssi, last,
                output ready);
endinterface

// ----- src/deauth_flood_monitor_core.sv -----
// ----------------------------------------------------------------------------
// Deauth flood monitor core
// Classifies management frames, keeps a rate window and an offender table.
// ----------------------------------------------------------------------------
// A qualifying frame searches the offender table memory one entry per cycle over the
// used entries (at most TABLE_DEPTH), stopping at a hit; other frames, ticks and
// clears need no search. A report makes one full table sweep per entry for its L
// listed entries. One item is in work at a time.
// Reset clears totals, window, table fill and control registers; no clearing pass.
module deauth_flood_monitor_core import dfm_pkg::*; #(
  parameter int TABLE_DEPTH    = 24,
  parameter int WINDOW_BUCKETS = 8,
  parameter int TOP_K          = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dfm_in_if.sink                in_i,
  dfm_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [RATE_W-1:0] thr_q, thr_d;
  logic [RPT_W-1:0]  rpt_q, rpt_d;
  dfm_cmd_t          cmd;
  dfm_sts_t          sts;

  // Configuration register writes.
  always_comb begin
    thr_d = thr_q;
    rpt_d = rpt_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ALERT_THR:  thr_d = cfg_wdata_i[RATE_W-1:0];
        CFG_REPORT_CNT: rpt_d = cfg_wdata_i[RPT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      rpt_q <= RPT_RESET;
    end else begin
      thr_q <= thr_d;
      rpt_q <= rpt_d;
    end
  end

  // Controller.
  dfm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Datapath.
  dfm_dp #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .WINDOW_BUCKETS (WINDOW_BUCKETS),
    .TOP_K          (TOP_K)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .thr_i  (thr_q),
    .rpt_i  (rpt_q),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

// ----- src/dfm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Deauth flood monitor controller
// Sequences item intake, table scans, report passes and result hand-off.
// ----------------------------------------------------------------------------
module dfm_ctrl import dfm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dfm_sts_t sts_i,
  output dfm_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_RSCAN = 5'b00100,
    ST_REMIT = 5'b01000,
    ST_EMIT  = 5'b10000
  } dfm_state_e;

  dfm_state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          case (sts_i.kind)
            KIND_FRAME: begin
              if (sts_i.qualify) begin
                cmd_o.scan_start = 1'b1;
                state_d          = ST_SCAN;
              end else begin
                state_d = ST_EMIT;
              end
            end
            KIND_REPORT: begin
              if (sts_i.limit_zero) begin
                state_d = ST_EMIT;
              end else begin
                cmd_o.scan_start = 1'b1;
                state_d          = ST_RSCAN;
              end
            end
            default: state_d = ST_EMIT;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.tbl_upd = 1'b1;
        if (sts_i.hit || sts_i.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_RSCAN: begin
        cmd_o.best_upd = 1'b1;
        if (sts_i.done) begin
          state_d = ST_REMIT;
        end
      end
      ST_REMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_entry = 1'b1;
          if (sts_i.last_entry) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.next_pass  = 1'b1;
            cmd_o.scan_start = 1'b1;
            state_d          = ST_RSCAN;
          end
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/dfm_dp.sv -----
// ----------------------------------------------------------------------------
// Deauth flood monitor datapath
// Counters, rate window, offender table memory, scan and top-k selection.
// ----------------------------------------------------------------------------
module dfm_dp import dfm_pkg::*; #(
  parameter int TABLE_DEPTH    = 24,
  parameter int WINDOW_BUCKETS = 8,
  parameter int TOP_K          = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dfm_in_if.sink            in_i,
  dfm_out_if.source         out_o,
  input  logic [RATE_W-1:0] thr_i,
  input  logic [RPT_W-1:0]  rpt_i,
  input  dfm_cmd_t          cmd_i,
  output dfm_sts_t          sts_o
);

`include "deauth_flood_monitor_core_assert.svh"

  localparam int TIDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UCNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W   = (WINDOW_BUCKETS > 1) ? $clog2(WINDOW_BUCKETS) : 1;
  localparam int SUM_RAW = BKT_W + $clog2(WINDOW_BUCKETS + 1);
  localparam int SUM_W   = (SUM_RAW > RATE_W) ? SUM_RAW : RATE_W;
  localparam int LIM_W   = $clog2(TOP_K + 1);
  localparam int CMP_A   = (UCNT_W > LIM_W) ? UCNT_W : LIM_W;
  localparam int CMP_W   = (CMP_A > RPT_W) ? CMP_A : RPT_W;

  // Input decode.
  logic       acc;
  dfm_kind_e  in_kind;
  logic [3:0] subtype;
  logic       qualify;
  dfm_class_e in_class;

  assign acc     = cmd_i.in_ready & in_i.valid;
  assign in_kind = dfm_kind_e'(in_i.kind);
  assign subtype = in_i.frame_ctrl[7:4];

  always_comb begin
    qualify  = in_i.mgmt_frame && (in_i.frame_len >= MIN_FRAME_LEN) &&
               (in_i.frame_ctrl[3:2] == TYPE_MGMT) &&
               (subtype inside {SUBTYPE_DEAUTH, SUBTYPE_DISASSOC});
    in_class = (subtype == SUBTYPE_DISASSOC) ? CLASS_DISASSOC : CLASS_DEAUTH;
  end

  // Totals, rate window and running window sum.
  logic [TOT_W-1:0] deauth_q, disassoc_q;
  logic [BKT_W-1:0] bkt_q [WINDOW_BUCKETS];
  logic [IDX_W-1:0] bidx_q, bidx_nxt, bsel;
  logic [BKT_W-1:0] bval;
  logic [SUM_W-1:0] sum_q;
  logic [UCNT_W-1:0] used_q, used_d;

  assign bidx_nxt = (bidx_q == IDX_W'(WINDOW_BUCKETS - 1)) ? '0 : bidx_q + 1'b1;
  assign bsel     = (in_kind == KIND_TICK) ? bidx_nxt : bidx_q;
  assign bval     = bkt_q[bsel];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deauth_q   <= '0;
      disassoc_q <= '0;
      bidx_q     <= '0;
      sum_q      <= '0;
      for (int i = 0; i < WINDOW_BUCKETS; i++) begin
        bkt_q[i] <= '0;
      end
    end else if (acc) begin
      case (in_kind)
        KIND_FRAME: begin
          if (qualify) begin
            if (in_class == CLASS_DISASSOC) begin
              disassoc_q <= disassoc_q + 1'b1;
            end else begin
              deauth_q <= deauth_q + 1'b1;
            end
            if (bval != '1) begin
              bkt_q[bsel] <= bval + 1'b1;
              sum_q       <= sum_q + 1'b1;
            end
          end
        end
        KIND_TICK: begin
          bidx_q      <= bidx_nxt;
          bkt_q[bsel] <= '0;
          sum_q       <= sum_q - SUM_W'(bval);
        end
        KIND_CLEAR: begin
          deauth_q   <= '0;
          disassoc_q <= '0;
          bidx_q     <= '0;
          sum_q      <= '0;
          for (int i = 0; i < WINDOW_BUCKETS; i++) begin
            bkt_q[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Latched item payload and per-item flags.
  logic [BSSID_W-1:0]       bssid_q;
  logic signed [RSSI_W-1:0] rssi_q;
  logic [CLASS_W-1:0]       class_q;
  logic                     drop_q;

  // Offender table memory with registered read.
  dfm_entry_t        tbl_mem [TABLE_DEPTH];
  dfm_entry_t        rd_q;
  dfm_entry_t        wr_data;
  logic              wr_en;
  logic [TIDX_W-1:0] wr_addr;

  // Scan pointer: issues one read per cycle while scanning, compares in the next cycle.
  logic [UCNT_W-1:0] ptr_q;
  logic              pend_q;
  logic [TIDX_W-1:0] pidx_q;
  logic              scanning, issue, hit, done, match;

  assign scanning = cmd_i.tbl_upd | cmd_i.best_upd;
  assign issue    = scanning && (ptr_q < used_q);
  assign match    = (rd_q.bssid == bssid_q);
  assign hit      = cmd_i.tbl_upd && pend_q && match;
  assign done     = scanning && !pend_q && !(ptr_q < used_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      ptr_q  <= '0;
      pend_q <= 1'b0;
    end else if (scanning) begin
      pend_q <= issue;
      if (issue) begin
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scanning) begin
      pidx_q <= ptr_q[TIDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q <= tbl_mem[ptr_q[TIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
  end

  // Table update on a hit, or on a miss at the end of the scan when the table is not full.
  logic table_full;
  assign table_full = !(used_q < UCNT_W'(TABLE_DEPTH));

  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = pidx_q;
    wr_data.bssid = bssid_q;
    wr_data.rssi  = rssi_q;
    wr_data.count = (rd_q.count == '1) ? rd_q.count : rd_q.count + 1'b1;
    used_d        = used_q;
    if (hit) begin
      wr_en = 1'b1;
    end else if (cmd_i.tbl_upd && done && !table_full) begin
      wr_en         = 1'b1;
      wr_addr       = used_q[TIDX_W-1:0];
      wr_data.count = CNT_W'(1);
      used_d        = used_q + 1'b1;
    end
    if (acc && in_kind == KIND_CLEAR) begin
      used_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      bssid_q <= in_i.bssid;
      rssi_q  <= in_i.rssi;
      class_q <= (in_kind == KIND_FRAME && qualify) ? in_class : CLASS_NONE;
      drop_q  <= 1'b0;
    end else if (cmd_i.tbl_upd && done && table_full) begin
      drop_q <= 1'b1;
    end
  end

  // Report length: min(report_count, TOP_K, used entries).
  logic [CMP_W-1:0] lim_rc, lim_tk, lim_us, lim_a, lim_x;
  assign lim_rc = CMP_W'(rpt_i);
  assign lim_tk = CMP_W'(TOP_K);
  assign lim_us = CMP_W'(used_q);
  assign lim_a  = (lim_rc < lim_tk) ? lim_rc : lim_tk;
  assign lim_x  = (lim_a < lim_us) ? lim_a : lim_us;

  // Top-k selection: each pass finds the best entry after the previous pick
  // in the order of descending count, then ascending index.
  logic [LIM_W-1:0]  limit_q, n_q;
  logic              have_prev_q, best_vld_q;
  logic [CNT_W-1:0]  prev_cnt_q;
  logic [TIDX_W-1:0] prev_idx_q, best_idx_q;
  dfm_entry_t        best_q;
  logic              cand, better, last_entry;

  assign cand = !have_prev_q || (rd_q.count < prev_cnt_q) ||
                ((rd_q.count == prev_cnt_q) && (pidx_q > prev_idx_q));
  assign better     = !best_vld_q || (rd_q.count > best_q.count);
  assign last_entry = (LIM_W'(n_q + 1'b1) == limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      best_vld_q  <= 1'b0;
      n_q         <= '0;
      limit_q     <= '0;
    end else begin
      if (acc && in_kind == KIND_REPORT) begin
        have_prev_q <= 1'b0;
        n_q         <= '0;
        limit_q     <= LIM_W'(lim_x);
      end else if (cmd_i.next_pass) begin
        have_prev_q <= 1'b1;
        n_q         <= n_q + 1'b1;
      end
      if (cmd_i.scan_start) begin
        best_vld_q <= 1'b0;
      end else if (cmd_i.best_upd && pend_q && cand && better) begin
        best_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.best_upd && pend_q && cand && better) begin
      best_q     <= rd_q;
      best_idx_q <= pidx_q;
    end
    if (cmd_i.next_pass) begin
      prev_cnt_q <= best_q.count;
      prev_idx_q <= best_idx_q;
    end
  end

  // Output register.
  logic              out_valid_q, out_free;
  dfm_out_t          out_q, out_d;
  logic [RATE_W-1:0] rate;

  assign out_free = !out_valid_q || out_o.ready;
  assign rate     = (sum_q > SUM_W'(RATE_MAX)) ? RATE_MAX : sum_q[RATE_W-1:0];

  always_comb begin
    out_d                = '0;
    out_d.window_rate    = rate;
    out_d.alert          = (rate >= thr_i);
    out_d.deauth_total   = deauth_q;
    out_d.disassoc_total = disassoc_q;
    if (cmd_i.out_entry) begin
      out_d.entry_valid = 1'b1;
      out_d.entry_bssid = best_q.bssid;
      out_d.entry_count = best_q.count;
      out_d.entry_rssi  = best_q.rssi;
      out_d.last        = last_entry;
    end else begin
      out_d.frame_class = class_q;
      out_d.table_drop  = drop_q;
      out_d.last        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  // Ports and status.
  assign in_i.ready           = cmd_i.in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.frame_class    = out_q.frame_class;
  assign out_o.table_drop     = out_q.table_drop;
  assign out_o.window_rate    = out_q.window_rate;
  assign out_o.alert          = out_q.alert;
  assign out_o.deauth_total   = out_q.deauth_total;
  assign out_o.disassoc_total = out_q.disassoc_total;
  assign out_o.entry_valid    = out_q.entry_valid;
  assign out_o.entry_bssid    = out_q.entry_bssid;
  assign out_o.entry_count    = out_q.entry_count;
  assign out_o.entry_rssi     = out_q.entry_rssi;
  assign out_o.last           = out_q.last;

  always_comb begin
    sts_o            = '0;
    sts_o.in_valid   = in_i.valid;
    sts_o.kind       = in_kind;
    sts_o.qualify    = qualify;
    sts_o.limit_zero = (lim_x == '0);
    sts_o.hit        = hit;
    sts_o.done       = done;
    sts_o.last_entry = last_entry;
    sts_o.out_free   = out_free;
  end

  // Assertions.
  `DFM_ASSERT(a_used_bound, clk_i, rst_ni, used_q <= UCNT_W'(TABLE_DEPTH))
  `DFM_ASSERT_NEVER(a_hit_range, clk_i, rst_ni, hit && (UCNT_W'(pidx_q) >= used_q))
  `DFM_ASSERT(a_hit_keeps_used, clk_i, rst_ni, hit |=> $stable(used_q))
  `DFM_ASSERT(a_pass_bound, clk_i, rst_ni, cmd_i.next_pass |-> (LIM_W'(n_q + 1'b1) < limit_q))
  `DFM_ASSERT(a_entry_found, clk_i, rst_ni, (cmd_i.out_load && cmd_i.out_entry) |-> best_vld_q)

endmodule
